### hdl/mwo_pkg.sv
// package for the multi-waveform phase oscillator
// holds codes, sequencer states, the shared multiplier request and the lfsr step
// no dependencies
`timescale 1ns / 1ps

package mwo_pkg;

   localparam int MUL_W       = 32;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int FIELD_W     = 16;
   localparam int WAVE_W      = 17;
   localparam int GAIN_W      = 18;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int WAVEFORM_W  = 3;
   localparam int INCREMENT_W = 15;
   localparam int FM_UNITS_PER_RAD = 10430;

   localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
   localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

   localparam logic signed [WAVE_W-1:0] W_PLUS_ONE  = 17'sd32768;
   localparam logic signed [WAVE_W-1:0] W_MINUS_ONE = -17'sd32768;

   localparam logic [CSR_INDEX_W-1:0] CSR_WAVEFORM  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INCREMENT = 2'd1;

   typedef enum logic [WAVEFORM_W-1:0] {
      WAVE_RAMP     = 3'd0,
      WAVE_SAW      = 3'd1,
      WAVE_SQUARE   = 3'd2,
      WAVE_TRIANGLE = 3'd3,
      WAVE_NOISE    = 3'd4,
      WAVE_STEP     = 3'd5
   } wave_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AM,
      ST_FM,
      ST_SCALE,
      ST_OUT,
      ST_DRAW,
      ST_SAT
   } state_type;

   typedef struct packed {
      logic                     enable;
      logic signed [MUL_W-1:0]  op_a;
      logic signed [MUL_W-1:0]  op_b;
   } mul_req_type;

   // galois lfsr, shifting right
   function automatic logic [31:0] lfsr_step(input logic [31:0] v);
      logic [31:0] s;
      s = {1'b0, v[31:1]};
      if (v[0]) begin
         s = s ^ LFSR_MASK;
      end
      return s;
   endfunction

endpackage

### hdl/mwo_mul.sv
// shared signed multiplier with registered product
// depends on mwo_pkg for operand widths and the request struct
`timescale 1ns / 1ps

module mwo_mul (
   input  logic                               clock,
   input  mwo_pkg::mul_req_type               mul_req,
   output logic signed [mwo_pkg::PROD_W-1:0]  product
);

   logic signed [mwo_pkg::PROD_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      if (mul_req.enable) begin
         product_ff <= mul_req.op_a * mul_req.op_b;
      end
   end

   assign product = product_ff;

endmodule

### hdl/mwo_shape.sv
// waveform shaper: forms the q1.15 waveform value from phase or noise
// depends on mwo_pkg for codes and constants
`timescale 1ns / 1ps

module mwo_shape #(
   parameter int PHASE_BITS = 16
) (
   input  logic [PHASE_BITS-1:0]               phase,
   input  logic [mwo_pkg::WAVEFORM_W-1:0]      waveform,
   input  logic [mwo_pkg::FIELD_W-1:0]         noise,
   input  logic [mwo_pkg::FIELD_W-1:0]         held,
   output logic signed [mwo_pkg::WAVE_W-1:0]   wave
);

   logic signed [mwo_pkg::FIELD_W-1:0] ph;
   logic [mwo_pkg::WAVE_W-1:0]         ph_abs;
   logic [mwo_pkg::WAVE_W:0]           tri_val;
   logic                               ph_positive;

   // top sixteen bits of phase, floor, or padded up for short accumulators
   generate
      if (PHASE_BITS >= mwo_pkg::FIELD_W) begin : g_top
         assign ph = phase[PHASE_BITS-1 -: mwo_pkg::FIELD_W];
      end else begin : g_pad
         assign ph = {phase, {(mwo_pkg::FIELD_W-PHASE_BITS){1'b0}}};
      end
   endgenerate

   assign ph_positive = !phase[PHASE_BITS-1] && (|phase);

   always_comb begin
      ph_abs  = ph[mwo_pkg::FIELD_W-1] ? (~{1'b1, ph} + mwo_pkg::WAVE_W'(1)) : {1'b0, ph};
      tri_val = {ph_abs, 1'b0} - {1'b0, mwo_pkg::W_PLUS_ONE};
      unique case (waveform)
         mwo_pkg::WAVE_RAMP:     wave = {ph[mwo_pkg::FIELD_W-1], ph};
         mwo_pkg::WAVE_SAW:      wave = -{ph[mwo_pkg::FIELD_W-1], ph};
         mwo_pkg::WAVE_SQUARE:   wave = ph_positive ? mwo_pkg::W_MINUS_ONE
                                                    : mwo_pkg::W_PLUS_ONE;
         mwo_pkg::WAVE_TRIANGLE: wave = tri_val[mwo_pkg::WAVE_W-1:0];
         mwo_pkg::WAVE_NOISE:    wave = {noise[mwo_pkg::FIELD_W-1], noise};
         mwo_pkg::WAVE_STEP:     wave = {held[mwo_pkg::FIELD_W-1], held};
         default:                wave = '0;
      endcase
   end

endmodule

### hdl/multi_waveform_phase_oscillator.sv
// Multi-waveform phase oscillator: one request is one sample tick and gives one
// saturated sample in the selected waveform (ramp, saw, square, triangle,
// noise or random step). A single shared 32x32 multiplier forms, in turn, the
// am product, the fm product, the fm product times the radian scale, and the
// waveform times the gain; a request passes the states AM, FM, SCALE, OUT, DRAW
// and SAT before the next is taken, with one more draw per phase wrap in random
// step mode (at most one wrap for PHASE_BITS of 16 or more). A finished sample
// waits in the output register; the next request may start meanwhile and only
// its final stage waits for the slot. Configuration writes are always taken
// and are meant for idle periods. No clearing pass is needed after reset.
// depends on mwo_pkg, mwo_mul and mwo_shape
`timescale 1ns / 1ps

module multi_waveform_phase_oscillator #(
   parameter int PHASE_BITS  = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [mwo_pkg::FIELD_W-1:0]     req_amp_level,
   input  logic signed [mwo_pkg::FIELD_W-1:0]     req_am_source,
   input  logic signed [mwo_pkg::FIELD_W-1:0]     req_am_depth,
   input  logic signed [mwo_pkg::FIELD_W-1:0]     req_fm_source,
   input  logic signed [mwo_pkg::FIELD_W-1:0]     req_fm_depth,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]          rsp_sample,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mwo_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [mwo_pkg::CSR_DATA_W-1:0]         csr_data
);

   localparam int SUM_W  = 34;
   localparam int WRAP_W = SUM_W - PHASE_BITS;
   localparam int SHIFT  = 31 - SAMPLE_BITS;
   localparam longint unsigned SCALE =
      (64'(mwo_pkg::FM_UNITS_PER_RAD) << PHASE_BITS) >> 16;
   localparam logic signed [mwo_pkg::PROD_W-1:0] MAXV =
      (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
   localparam logic signed [mwo_pkg::PROD_W-1:0] MINV = -MAXV - 64'sd1;
   localparam logic [PHASE_BITS-1:0] PHASE_MSB = {1'b1, {(PHASE_BITS-1){1'b0}}};

   mwo_pkg::state_type state_ff, state_in;

   logic [mwo_pkg::WAVEFORM_W-1:0]          wave_ff;
   logic [mwo_pkg::INCREMENT_W-1:0]         inc_ff;
   logic [PHASE_BITS-1:0]                   phase_ff, phase_in;
   logic [31:0]                             noise_ff, noise_in;
   logic [mwo_pkg::FIELD_W-1:0]             held_ff, held_in;
   logic [WRAP_W-1:0]                       wraps_ff, wraps_in;

   logic signed [mwo_pkg::FIELD_W-1:0]      amp_ff, am_ff, aa_ff, fm_ff, fa_ff;
   logic signed [mwo_pkg::WAVE_W-1:0]       w_ff, w_in;
   logic signed [mwo_pkg::GAIN_W-1:0]       gain_ff, gain_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0]           sample_ff, sample_in;

   mwo_pkg::mul_req_type                    mul_req;
   logic signed [mwo_pkg::PROD_W-1:0]       product;

   logic                                    accept;
   logic                                    slot_free;
   logic [31:0]                             noise_next;
   logic signed [31:0]                      prod_lo;
   logic [31:0]                             prod_mag;
   logic [31:0]                             step;
   logic [SUM_W-1:0]                        sum;
   logic signed [mwo_pkg::PROD_W-1:0]       shifted;
   logic                                    advances;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != mwo_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign noise_next = mwo_pkg::lfsr_step(noise_ff);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = sample_ff;

   mwo_shape #(
      .PHASE_BITS (PHASE_BITS)
   ) u_shape (
      .phase    (phase_ff),
      .waveform (wave_ff),
      .noise    (noise_next[mwo_pkg::FIELD_W-1:0]),
      .held     (held_ff),
      .wave     (w_in)
   );

   mwo_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .product (product)
   );

   // magnitude of the previous product, at most 2^30
   assign prod_lo  = product[31:0];
   assign prod_mag = prod_lo[31] ? 32'(-prod_lo) : 32'(prod_lo);
   assign step     = 32'(inc_ff) + product[61:30];
   assign sum      = SUM_W'({1'b0, phase_ff ^ PHASE_MSB}) + SUM_W'(step);
   assign shifted  = product >>> SHIFT;
   assign advances = (wave_ff <= 3'(mwo_pkg::WAVE_TRIANGLE)) ||
                     (wave_ff == 3'(mwo_pkg::WAVE_STEP));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mwo_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wave_ff      <= '0;
         inc_ff       <= '0;
         phase_ff     <= '0;
         noise_ff     <= mwo_pkg::LFSR_SEED;
         held_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         noise_ff     <= noise_in;
         held_ff      <= held_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == mwo_pkg::CSR_WAVEFORM) begin
               wave_ff <= csr_data[mwo_pkg::WAVEFORM_W-1:0];
            end else if (csr_index == mwo_pkg::CSR_INCREMENT) begin
               inc_ff <= csr_data[mwo_pkg::INCREMENT_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         amp_ff <= req_amp_level;
         am_ff  <= req_am_source;
         aa_ff  <= req_am_depth;
         fm_ff  <= req_fm_source;
         fa_ff  <= req_fm_depth;
         w_ff   <= w_in;
      end
      gain_ff   <= gain_in;
      wraps_ff  <= wraps_in;
      sample_ff <= sample_in;
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      noise_in     = noise_ff;
      held_in      = held_ff;
      gain_in      = gain_ff;
      wraps_in     = wraps_ff;
      sample_in    = sample_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_req      = '{enable: 1'b0, op_a: '0, op_b: '0};
      unique case (state_ff)
         mwo_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = mwo_pkg::ST_AM;
               // noise draws before the sample is formed
               if (wave_ff == 3'(mwo_pkg::WAVE_NOISE)) begin
                  noise_in = noise_next;
               end
            end
         end
         mwo_pkg::ST_AM: begin
            mul_req  = '{enable: 1'b1, op_a: 32'(am_ff), op_b: 32'(aa_ff)};
            state_in = mwo_pkg::ST_FM;
         end
         mwo_pkg::ST_FM: begin
            gain_in  = mwo_pkg::GAIN_W'(amp_ff) +
                       mwo_pkg::GAIN_W'(prod_mag[30:15]);
            mul_req  = '{enable: 1'b1, op_a: 32'(fm_ff), op_b: 32'(fa_ff)};
            state_in = mwo_pkg::ST_SCALE;
         end
         mwo_pkg::ST_SCALE: begin
            mul_req  = '{enable: 1'b1, op_a: signed'({1'b0, prod_mag[30:0]}),
                         op_b: signed'({1'b0, SCALE[30:0]})};
            state_in = mwo_pkg::ST_OUT;
         end
         mwo_pkg::ST_OUT: begin
            wraps_in = '0;
            if (advances) begin
               phase_in = sum[PHASE_BITS-1:0] ^ PHASE_MSB;
               if (wave_ff == 3'(mwo_pkg::WAVE_STEP)) begin
                  wraps_in = sum[SUM_W-1:PHASE_BITS];
               end
            end
            mul_req  = '{enable: 1'b1, op_a: 32'(w_ff), op_b: 32'(gain_ff)};
            state_in = mwo_pkg::ST_DRAW;
         end
         mwo_pkg::ST_DRAW: begin
            // one draw per wrap, the last one is kept
            if (wraps_ff != '0) begin
               noise_in = noise_next;
               held_in  = noise_next[mwo_pkg::FIELD_W-1:0];
               wraps_in = wraps_ff - WRAP_W'(1);
            end else begin
               state_in = mwo_pkg::ST_SAT;
            end
         end
         mwo_pkg::ST_SAT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (shifted > MAXV) begin
                  sample_in = MAXV[SAMPLE_BITS-1:0];
               end else if (shifted < MINV) begin
                  sample_in = MINV[SAMPLE_BITS-1:0];
               end else begin
                  sample_in = shifted[SAMPLE_BITS-1:0];
               end
               state_in = mwo_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mwo_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == mwo_pkg::ST_AM))
      else $error("accepted request did not start the sequencer");

   a_noise_holds_phase: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mwo_pkg::ST_OUT && wave_ff == 3'(mwo_pkg::WAVE_NOISE))
      |=> $stable(phase_ff))
      else $error("phase moved in noise mode");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mwo_pkg::ST_SAT && slot_free) |=> rsp_valid_ff)
      else $error("finished sample not presented");

   a_undefined_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mwo_pkg::ST_SAT && slot_free &&
       wave_ff > 3'(mwo_pkg::WAVE_STEP)) |=> (sample_ff == '0))
      else $error("undefined waveform gave a nonzero sample");

   a_lfsr_live: assert property (@(posedge clock) disable iff (reset)
      noise_ff != '0)
      else $error("noise register reached the all-zero lock");
`endif

endmodule

### bench/tb.sv
// testbench for multi_waveform_phase_oscillator: a directed table of sample ticks, then
// random ticks over many register settings, every sample checked against a table value or a predictor
// depends on mwo_pkg and the oscillator rtl
`timescale 1ns / 1ps

module tb;

   localparam logic signed [mwo_pkg::FIELD_W-1:0] Q_MAX = 16'sh7FFF;
   localparam logic signed [mwo_pkg::FIELD_W-1:0] Q_MIN = 16'sh8000;
   localparam logic signed [mwo_pkg::FIELD_W-1:0] ZERO  = 16'sh0000;
   // waveform codes the block leaves undefined
   localparam logic [mwo_pkg::WAVEFORM_W-1:0] WAVE_RSVD_LO = 3'd6;
   localparam logic [mwo_pkg::WAVEFORM_W-1:0] WAVE_RSVD_HI = 3'd7;
   localparam int PLAN_ROWS = 24;
   localparam int DRAIN_CYCLES = 16;

   typedef struct packed {
      logic signed [mwo_pkg::FIELD_W-1:0] amp;
      logic signed [mwo_pkg::FIELD_W-1:0] am_src;
      logic signed [mwo_pkg::FIELD_W-1:0] am_dep;
      logic signed [mwo_pkg::FIELD_W-1:0] fm_src;
      logic signed [mwo_pkg::FIELD_W-1:0] fm_dep;
   } tick_type;

   typedef struct packed {
      logic [mwo_pkg::CSR_DATA_W-1:0] wave_word;
      logic [mwo_pkg::CSR_DATA_W-1:0] inc_word;
      tick_type                       tick;
      logic                           typed;
      logic [15:0]                    want;
   } row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   tick_type                        req_tick = '0;
   logic                            req_typed = 1'b0;
   logic [15:0]                     req_want = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic signed [15:0]              rsp_sample;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [mwo_pkg::CSR_INDEX_W-1:0] csr_index = mwo_pkg::CSR_WAVEFORM;
   logic [mwo_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   // oscillator state as the predictor sees it
   logic [15:0]                     osc_phase = '0;
   logic [31:0]                     osc_noise = mwo_pkg::LFSR_SEED;
   logic [15:0]                     osc_held = '0;
   logic [mwo_pkg::WAVEFORM_W-1:0]  osc_wave = mwo_pkg::WAVE_RAMP;
   logic [mwo_pkg::INCREMENT_W-1:0] osc_inc = '0;

   logic [15:0] samples_due[$];
   int          faults = 0;
   logic        calm = 1'b0;
   logic        hold_off = 1'b0;

   row_type plan [PLAN_ROWS] = '{
      '{{13'h0000, mwo_pkg::WAVE_RAMP}, 16'h0000,
        '{Q_MAX, ZERO, ZERO, ZERO, ZERO}, 1'b1, ZERO},
      '{{13'h0000, mwo_pkg::WAVE_SQUARE}, 16'h0000,
        '{Q_MAX, ZERO, ZERO, ZERO, ZERO}, 1'b1, Q_MAX},
      '{{13'h0000, mwo_pkg::WAVE_SQUARE}, 16'h0000,
        '{Q_MIN, ZERO, ZERO, ZERO, ZERO}, 1'b1, Q_MIN},
      '{{13'h0000, mwo_pkg::WAVE_SQUARE}, 16'h0000,
        '{Q_MAX, Q_MIN, Q_MIN, ZERO, ZERO}, 1'b1, Q_MAX},
      '{{13'h0000, mwo_pkg::WAVE_SQUARE}, 16'h0000,
        '{ZERO, Q_MAX, Q_MIN, ZERO, ZERO}, 1'b1, Q_MAX},
      '{{13'h0000, mwo_pkg::WAVE_TRIANGLE}, 16'h0000,
        '{Q_MAX, ZERO, ZERO, ZERO, ZERO}, 1'b1, 16'sh8001},
      '{{13'h0000, mwo_pkg::WAVE_TRIANGLE}, 16'h0000,
        '{Q_MAX, Q_MAX, Q_MAX, ZERO, ZERO}, 1'b1, Q_MIN},
      '{{13'h0000, mwo_pkg::WAVE_NOISE}, 16'h0000,
        '{Q_MAX, ZERO, ZERO, Q_MIN, Q_MIN}, 1'b1, 16'sd2},
      '{{13'h0000, mwo_pkg::WAVE_NOISE}, 16'h0000,
        '{Q_MIN, ZERO, ZERO, Q_MAX, Q_MAX}, 1'b1, -16'sd2},
      '{{13'h0000, WAVE_RSVD_LO}, 16'h0000,
        '{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX}, 1'b1, ZERO},
      '{{13'h1FFF, WAVE_RSVD_HI}, 16'h0000,
        '{Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b1, ZERO},
      '{{13'h1FFF, mwo_pkg::WAVE_RAMP}, 16'hFFFF,
        '{Q_MAX, ZERO, ZERO, Q_MIN, Q_MIN}, 1'b1, ZERO},
      '{{13'h1FFF, mwo_pkg::WAVE_RAMP}, 16'hFFFF,
        '{Q_MAX, ZERO, ZERO, Q_MIN, Q_MIN}, 1'b0, ZERO},
      '{{13'h0000, mwo_pkg::WAVE_SAW}, 16'hFFFF,
        '{Q_MIN, ZERO, ZERO, Q_MAX, Q_MIN}, 1'b0, ZERO},
      '{{13'h0000, mwo_pkg::WAVE_SAW}, 16'hFFFF,
        '{Q_MAX, Q_MIN, Q_MAX, ZERO, ZERO}, 1'b0, ZERO},
      '{{13'h0000, mwo_pkg::WAVE_SQUARE}, 16'h0001,
        '{Q_MAX, ZERO, ZERO, ZERO, ZERO}, 1'b0, ZERO},
      '{{13'h0000, mwo_pkg::WAVE_SQUARE}, 16'h0001,
        '{Q_MAX, ZERO, ZERO, ZERO, ZERO}, 1'b0, ZERO},
      '{{13'h0000, mwo_pkg::WAVE_TRIANGLE}, 16'd12345,
        '{16'shFFFF, Q_MIN, Q_MIN, ZERO, ZERO}, 1'b0, ZERO},
      '{{13'h0000, mwo_pkg::WAVE_STEP}, 16'h7FFF,
        '{Q_MAX, ZERO, ZERO, Q_MIN, Q_MIN}, 1'b0, ZERO},
      '{{13'h0000, mwo_pkg::WAVE_STEP}, 16'h7FFF,
        '{Q_MAX, ZERO, ZERO, Q_MIN, Q_MIN}, 1'b0, ZERO},
      '{{13'h0000, mwo_pkg::WAVE_STEP}, 16'h7FFF,
        '{Q_MIN, 16'sd1, 16'sd1, Q_MAX, Q_MAX}, 1'b0, ZERO},
      '{{13'h0000, mwo_pkg::WAVE_STEP}, 16'h0000,
        '{Q_MAX, ZERO, ZERO, ZERO, ZERO}, 1'b0, ZERO},
      '{{13'h0000, mwo_pkg::WAVE_RAMP}, 16'h0000,
        '{Q_MIN, Q_MIN, Q_MIN, 16'sd1, 16'sd1}, 1'b0, ZERO},
      '{{13'h0000, mwo_pkg::WAVE_RAMP}, 16'h0000,
        '{Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX}, 1'b0, ZERO}
   };

   multi_waveform_phase_oscillator dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_amp_level (req_tick.amp),
      .req_am_source (req_tick.am_src),
      .req_am_depth  (req_tick.am_dep),
      .req_fm_source (req_tick.fm_src),
      .req_fm_depth  (req_tick.fm_dep),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sample    (rsp_sample),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] draw_noise();
      osc_noise = {1'b0, osc_noise[31:1]} ^ (osc_noise[0] ? mwo_pkg::LFSR_MASK : 32'h0);
      return osc_noise[15:0];
   endfunction

   // returns high when the phase wraps past +pi (never more than once at 16 bits)
   function automatic logic advance_phase(input logic signed [15:0] fm,
                                          input logic signed [15:0] fa);
      longint mag;
      longint n;
      mag = longint'(fm) * longint'(fa);
      if (mag < 0) begin
         mag = -mag;
      end
      n = longint'($signed(osc_phase)) + longint'(osc_inc)
          + ((mag * mwo_pkg::FM_UNITS_PER_RAD) >>> 30);
      osc_phase = n[15:0];
      return n >= 32768;
   endfunction

   function automatic logic [15:0] next_sample(input tick_type t);
      longint prod;
      longint gain;
      longint w;
      longint r;
      prod = longint'(t.am_src) * longint'(t.am_dep);
      if (prod < 0) begin
         prod = -prod;
      end
      gain = longint'(t.amp) + (prod >>> 15);
      case (osc_wave)
         mwo_pkg::WAVE_RAMP: begin
            w = longint'($signed(osc_phase));
            void'(advance_phase(t.fm_src, t.fm_dep));
         end
         mwo_pkg::WAVE_SAW: begin
            w = -longint'($signed(osc_phase));
            void'(advance_phase(t.fm_src, t.fm_dep));
         end
         mwo_pkg::WAVE_SQUARE: begin
            w = ($signed(osc_phase) > 0) ? longint'(mwo_pkg::W_MINUS_ONE)
                                         : longint'(mwo_pkg::W_PLUS_ONE);
            void'(advance_phase(t.fm_src, t.fm_dep));
         end
         mwo_pkg::WAVE_TRIANGLE: begin
            w = longint'($signed(osc_phase));
            if (w < 0) begin
               w = -w;
            end
            w = 2 * w + longint'(mwo_pkg::W_MINUS_ONE);
            void'(advance_phase(t.fm_src, t.fm_dep));
         end
         mwo_pkg::WAVE_NOISE: begin
            w = longint'($signed(draw_noise()));
         end
         mwo_pkg::WAVE_STEP: begin
            // the held value is used before the phase moves on
            w = longint'($signed(osc_held));
            if (advance_phase(t.fm_src, t.fm_dep)) begin
               osc_held = draw_noise();
            end
         end
         default: begin
            return '0;
         end
      endcase
      r = (w * gain) >>> 15;
      if (r > 32767) begin
         r = 32767;
      end else if (r < -32768) begin
         r = -32768;
      end
      return r[15:0];
   endfunction

   always @(posedge clock) begin : check_samples
      logic [15:0] want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            want = next_sample(req_tick);
            if (req_typed) begin
               want = req_want;
            end
            samples_due.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (samples_due.size() == 0) begin
               if (faults < 10) begin
                  $display("unexpected sample %0d at %0t", rsp_sample, $realtime);
               end
               faults++;
            end else begin
               want = samples_due.pop_front();
               if (rsp_sample !== want) begin
                  if (faults < 10) begin
                     $display("sample mismatch: expected %0d, got %0d at %0t",
                              $signed(want), rsp_sample, $realtime);
                  end
                  faults++;
               end
            end
         end
      end
   end

   // receiver side: short random stalls, and one long hold-off on request
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_off = 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic offer(input tick_type t, input logic typed, input logic [15:0] want);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_tick  <= t;
      req_typed <= typed;
      req_want  <= want;
      do @(posedge clock); while (req_stall);
   endtask

   // wait for every outstanding sample, then let the pipeline empty
   task automatic settle();
      do @(posedge clock); while (samples_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [mwo_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [mwo_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == mwo_pkg::CSR_WAVEFORM) begin
         osc_wave = data[mwo_pkg::WAVEFORM_W-1:0];
      end else begin
         osc_inc = data[mwo_pkg::INCREMENT_W-1:0];
      end
      @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_q15();
      case ($urandom_range(0, 9))
         0: return Q_MIN;
         1: return Q_MAX;
         2: return ZERO;
         3: return 16'($urandom_range(0, 15));
         4: return -16'($urandom_range(1, 16));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      int k;
      int p;
      int n_ticks;
      logic [31:0] bits;
      logic [mwo_pkg::WAVEFORM_W-1:0] code;
      logic [mwo_pkg::CSR_DATA_W-1:0] wave_now;
      logic [mwo_pkg::CSR_DATA_W-1:0] inc_now;
      logic [mwo_pkg::CSR_DATA_W-1:0] inc_word;
      tick_type t;
      wave_now = '0;
      inc_now  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < PLAN_ROWS; k++) begin
         if (plan[k].wave_word != wave_now || plan[k].inc_word != inc_now) begin
            req_valid <= 1'b0;
            settle();
            write_reg(mwo_pkg::CSR_WAVEFORM, plan[k].wave_word);
            write_reg(mwo_pkg::CSR_INCREMENT, plan[k].inc_word);
            wave_now = plan[k].wave_word;
            inc_now  = plan[k].inc_word;
         end
         offer(plan[k].tick, plan[k].typed, plan[k].want);
      end

      for (p = 0; p < 19; p++) begin
         req_valid <= 1'b0;
         settle();
         calm = (p >= 16);
         bits = $urandom;
         code = 3'(p % 8);
         case (p % 4)
            0: inc_word = {bits[20], 15'h0000};
            1: inc_word = {bits[20], 15'h7FFF};
            2: inc_word = {1'b0, 15'($urandom_range(0, 600))};
            default: inc_word = bits[31:16];
         endcase
         write_reg(mwo_pkg::CSR_WAVEFORM, {bits[12:0], code});
         write_reg(mwo_pkg::CSR_INCREMENT, inc_word);
         // undefined codes give nothing but zeros, so keep those phases short
         n_ticks = (code == WAVE_RSVD_LO || code == WAVE_RSVD_HI) ? 16 : 72;
         if (p == 2) begin
            hold_off = 1'b1;
         end
         for (k = 0; k < n_ticks; k++) begin
            t.amp    = pick_q15();
            t.am_src = pick_q15();
            t.am_dep = pick_q15();
            t.fm_src = pick_q15();
            t.fm_dep = pick_q15();
            offer(t, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (samples_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      faults += samples_due.size();
      if (faults == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

### files.f
hdl/mwo_pkg.sv
hdl/mwo_mul.sv
hdl/mwo_shape.sv
hdl/multi_waveform_phase_oscillator.sv
bench/tb.sv
